// File: hw/rtl/drd_pkg.sv
package drd_pkg;

    localparam int MAX_CLASSES = 255;
    localparam int BOX_WORDS   = 4;
    localparam int POS_W       = $clog2(MAX_CLASSES + BOX_WORDS);

    localparam int WORD_W   = 16;
    localparam int COUNT_W  = 8;
    localparam int IMG_W    = 13;
    localparam int COORD_W  = 17;
    localparam int CLASS_W  = 9;
    localparam int DATA_W   = 16;
    localparam int INDEX_W  = 3;

    localparam int X5_W     = 19;
    localparam int PROD_W   = X5_W + WORD_W + 1;
    localparam int SPROD_W  = 2 * WORD_W;

    typedef enum logic [INDEX_W-1:0] {
        REG_CLASS_COUNT     = 3'd0,
        REG_SCORE_THRESHOLD = 3'd1,
        REG_PAD_LEFT        = 3'd2,
        REG_PAD_TOP         = 3'd3,
        REG_RECIP_SCALE     = 3'd4,
        REG_IMAGE_WIDTH     = 3'd5,
        REG_IMAGE_HEIGHT    = 3'd6
    } reg_index_t;

    localparam logic [COUNT_W-1:0] RST_CLASS_COUNT     = 8'd80;
    localparam logic [WORD_W-1:0]  RST_SCORE_THRESHOLD = 16'd16384;
    localparam logic [WORD_W-1:0]  RST_PAD             = 16'd0;
    localparam logic [WORD_W-1:0]  RST_RECIP_SCALE     = 16'd4096;
    localparam logic [IMG_W-1:0]   RST_IMAGE_WIDTH     = 13'd1280;
    localparam logic [IMG_W-1:0]   RST_IMAGE_HEIGHT    = 13'd720;

endpackage

// File: hw/rtl/drd_if.sv
interface drd_in_if;
    logic                           valid;
    logic                           ready;
    logic [drd_pkg::WORD_W-1:0]     word;
    logic                           row_start;

    modport source (output valid, output word, output row_start, input ready);
    modport sink (input valid, input word, input row_start, output ready);
endinterface

interface drd_out_if;
    logic                               valid;
    logic                               ready;
    logic [drd_pkg::COORD_W-1:0]        left;
    logic [drd_pkg::COORD_W-1:0]        top;
    logic [drd_pkg::COORD_W-1:0]        box_width;
    logic [drd_pkg::COORD_W-1:0]        box_height;
    logic signed [drd_pkg::CLASS_W-1:0] class_index;
    logic [drd_pkg::WORD_W-1:0]         confidence;

    modport source (output valid, output left, output top, output box_width,
                    output box_height, output class_index, output confidence,
                    input ready);
    modport sink (input valid, input left, input top, input box_width,
                  input box_height, input class_index, input confidence,
                  output ready);
endinterface

interface drd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [drd_pkg::INDEX_W-1:0]    reg_index;
    logic [drd_pkg::DATA_W-1:0]     data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink (input valid, input reg_index, input data, output ready);
endinterface

// File: hw/rtl/drd_axis_map.sv
module drd_axis_map (
    input  logic signed [drd_pkg::PROD_W-1:0]  corner_prod,
    input  logic [drd_pkg::SPROD_W-1:0]        size_prod,
    input  logic [drd_pkg::IMG_W-1:0]          image_size,
    output logic [drd_pkg::COORD_W-1:0]        corner,
    output logic [drd_pkg::COORD_W-1:0]        size
);

    logic signed [drd_pkg::PROD_W:0]     rounded;
    logic signed [drd_pkg::PROD_W-13:0]  corner_raw;
    logic signed [drd_pkg::PROD_W-13:0]  edge_s;
    logic [drd_pkg::COORD_W-1:0]         edge_u;
    logic [drd_pkg::SPROD_W:0]           size_sum;
    logic [drd_pkg::SPROD_W-12:0]        size_raw;
    logic [drd_pkg::COORD_W-1:0]         room;

    always_comb
    begin
        edge_u     = {image_size, 4'b0000};
        edge_s     = $signed({{(drd_pkg::PROD_W - 12 - drd_pkg::COORD_W){1'b0}}, edge_u});
        rounded    = $signed({corner_prod[drd_pkg::PROD_W-1], corner_prod})
                     + $signed((drd_pkg::PROD_W + 1)'(4096));
        corner_raw = rounded[drd_pkg::PROD_W:13];
        if (corner_raw < 0)
        begin
            corner = '0;
        end
        else if (corner_raw > edge_s)
        begin
            corner = edge_u;
        end
        else
        begin
            corner = corner_raw[drd_pkg::COORD_W-1:0];
        end
        room     = edge_u - corner;
        size_sum = {1'b0, size_prod} + (drd_pkg::SPROD_W + 1)'(2048);
        size_raw = size_sum[drd_pkg::SPROD_W:12];
        if (size_raw > {{(drd_pkg::SPROD_W - 11 - drd_pkg::COORD_W){1'b0}}, room})
        begin
            size = room;
        end
        else
        begin
            size = size_raw[drd_pkg::COORD_W-1:0];
        end
    end

endmodule

// File: hw/rtl/detection_row_decode.sv
// Decodes a stream of detector row words, one word per cycle, into boxes. Each row is four
// Q12.4 box words followed by class_count Q0.16 scores (one score if class_count is zero); a
// running argmax picks the best class and on the last score a row that meets the threshold is
// mapped to frame coordinates and, if its width and height are both non-zero, presented as one
// item on the output. A word is decided in the input register stage, and a kept row then passes
// the decoded-row register, a multiply stage and the result register before its box is
// presented. A word is accepted in every cycle unless the output is stalled and the stages
// behind it are full. Configuration registers take effect at once and are meant to be written
// only while no row is in flight.
module detection_row_decode (
    input  logic       clk,
    input  logic       rst_n,
    drd_in_if.sink     words,
    drd_out_if.source  boxes,
    drd_cfg_if.sink    cfg
);

    logic [drd_pkg::COUNT_W-1:0]  class_count_reg;
    logic [drd_pkg::WORD_W-1:0]   score_threshold_reg;
    logic [drd_pkg::WORD_W-1:0]   pad_left_reg;
    logic [drd_pkg::WORD_W-1:0]   pad_top_reg;
    logic [drd_pkg::WORD_W-1:0]   recip_scale_reg;
    logic [drd_pkg::IMG_W-1:0]    image_width_reg;
    logic [drd_pkg::IMG_W-1:0]    image_height_reg;

    logic                         s1_valid_reg;
    logic [drd_pkg::WORD_W-1:0]   s1_word_reg;
    logic                         s1_start_reg;

    logic [drd_pkg::POS_W-1:0]    position_reg;
    logic [drd_pkg::POS_W-1:0]    position_next;
    logic [drd_pkg::WORD_W-1:0]   box_reg [drd_pkg::BOX_WORDS];
    logic [drd_pkg::WORD_W-1:0]   best_score_reg;
    logic [drd_pkg::WORD_W-1:0]   best_score_next;
    logic signed [drd_pkg::CLASS_W-1:0] best_class_reg;
    logic signed [drd_pkg::CLASS_W-1:0] best_class_next;

    logic                                s2_valid_reg;
    logic                                s2_valid_next;
    logic signed [drd_pkg::X5_W-1:0]     s2_x5_reg;
    logic signed [drd_pkg::X5_W-1:0]     s2_y5_reg;
    logic [drd_pkg::WORD_W-1:0]          s2_w_reg;
    logic [drd_pkg::WORD_W-1:0]          s2_h_reg;
    logic signed [drd_pkg::CLASS_W-1:0]  s2_class_reg;
    logic [drd_pkg::WORD_W-1:0]          s2_conf_reg;

    logic                                s3_valid_reg;
    logic signed [drd_pkg::PROD_W-1:0]   s3_px_reg;
    logic signed [drd_pkg::PROD_W-1:0]   s3_py_reg;
    logic [drd_pkg::SPROD_W-1:0]         s3_pw_reg;
    logic [drd_pkg::SPROD_W-1:0]         s3_ph_reg;
    logic signed [drd_pkg::CLASS_W-1:0]  s3_class_reg;
    logic [drd_pkg::WORD_W-1:0]          s3_conf_reg;

    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [drd_pkg::COORD_W-1:0]         out_left_reg;
    logic [drd_pkg::COORD_W-1:0]         out_top_reg;
    logic [drd_pkg::COORD_W-1:0]         out_bw_reg;
    logic [drd_pkg::COORD_W-1:0]         out_bh_reg;
    logic signed [drd_pkg::CLASS_W-1:0]  out_class_reg;
    logic [drd_pkg::WORD_W-1:0]          out_conf_reg;

    logic                                s3_go;
    logic                                s2_go;
    logic                                s1_go;
    logic                                s1_fire;
    logic                                in_fire;
    logic [drd_pkg::POS_W-1:0]           pos;
    logic [drd_pkg::COUNT_W-1:0]         n;
    logic                                last_score;
    logic signed [drd_pkg::X5_W-1:0]     x5;
    logic signed [drd_pkg::X5_W-1:0]     y5;
    logic signed [drd_pkg::WORD_W:0]     rs_s;
    logic [drd_pkg::COORD_W-1:0]         left_c;
    logic [drd_pkg::COORD_W-1:0]         top_c;
    logic [drd_pkg::COORD_W-1:0]         bw_c;
    logic [drd_pkg::COORD_W-1:0]         bh_c;

    assign s3_go   = !out_valid_reg || boxes.ready;
    assign s2_go   = !s3_valid_reg || s3_go;
    assign s1_go   = !s2_valid_reg || s2_go;
    assign s1_fire = s1_valid_reg && s1_go;
    assign words.ready = !s1_valid_reg || s1_go;
    assign in_fire = words.valid && words.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg     <= drd_pkg::RST_CLASS_COUNT;
            score_threshold_reg <= drd_pkg::RST_SCORE_THRESHOLD;
            pad_left_reg        <= drd_pkg::RST_PAD;
            pad_top_reg         <= drd_pkg::RST_PAD;
            recip_scale_reg     <= drd_pkg::RST_RECIP_SCALE;
            image_width_reg     <= drd_pkg::RST_IMAGE_WIDTH;
            image_height_reg    <= drd_pkg::RST_IMAGE_HEIGHT;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                drd_pkg::REG_CLASS_COUNT:     class_count_reg <= cfg.data[drd_pkg::COUNT_W-1:0];
                drd_pkg::REG_SCORE_THRESHOLD: score_threshold_reg <= cfg.data;
                drd_pkg::REG_PAD_LEFT:        pad_left_reg <= cfg.data;
                drd_pkg::REG_PAD_TOP:         pad_top_reg <= cfg.data;
                drd_pkg::REG_RECIP_SCALE:     recip_scale_reg <= cfg.data;
                drd_pkg::REG_IMAGE_WIDTH:     image_width_reg <= cfg.data[drd_pkg::IMG_W-1:0];
                drd_pkg::REG_IMAGE_HEIGHT:    image_height_reg <= cfg.data[drd_pkg::IMG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (words.ready)
        begin
            s1_valid_reg <= words.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_word_reg  <= words.word;
            s1_start_reg <= words.row_start;
        end
    end

    always_comb
    begin
        pos = s1_start_reg ? '0 : position_reg;
        n   = (class_count_reg == '0) ? drd_pkg::COUNT_W'(1) : class_count_reg;
        if (drd_pkg::POS_W'(n) > drd_pkg::POS_W'(drd_pkg::MAX_CLASSES))
        begin
            n = drd_pkg::COUNT_W'(drd_pkg::MAX_CLASSES);
        end
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        last_score      = 1'b0;
        if (pos < drd_pkg::POS_W'(drd_pkg::BOX_WORDS))
        begin
            position_next = pos + 1'b1;
            if (pos == '0)
            begin
                best_score_next = '0;
                best_class_next = '1;
            end
        end
        else
        begin
            if (s1_word_reg > best_score_reg)
            begin
                best_score_next = s1_word_reg;
                best_class_next = $signed(drd_pkg::CLASS_W'(pos - drd_pkg::POS_W'(drd_pkg::BOX_WORDS)));
            end
            if (pos < drd_pkg::POS_W'(drd_pkg::BOX_WORDS - 1) + drd_pkg::POS_W'(n))
            begin
                position_next = pos + 1'b1;
            end
            else
            begin
                position_next = '0;
                last_score    = 1'b1;
            end
        end
        s2_valid_next = last_score && (best_score_next >= score_threshold_reg);
        x5 = $signed({2'b00, box_reg[0], 1'b0}) - $signed({3'b000, box_reg[2]})
             - $signed({2'b00, pad_left_reg, 1'b0});
        y5 = $signed({2'b00, box_reg[1], 1'b0}) - $signed({3'b000, box_reg[3]})
             - $signed({2'b00, pad_top_reg, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            best_score_reg <= '0;
            best_class_reg <= '1;
        end
        else if (s1_fire)
        begin
            position_reg   <= position_next;
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && (pos < drd_pkg::POS_W'(drd_pkg::BOX_WORDS)))
        begin
            box_reg[pos[1:0]] <= s1_word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_go)
            begin
                s2_valid_reg <= s1_fire && s2_valid_next;
            end
            if (s2_go)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s2_valid_next)
        begin
            s2_x5_reg    <= x5;
            s2_y5_reg    <= y5;
            s2_w_reg     <= box_reg[2];
            s2_h_reg     <= box_reg[3];
            s2_class_reg <= best_class_next;
            s2_conf_reg  <= best_score_next;
        end
    end

    assign rs_s = $signed({1'b0, recip_scale_reg});

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_go)
        begin
            s3_px_reg    <= drd_pkg::PROD_W'(s2_x5_reg) * drd_pkg::PROD_W'(rs_s);
            s3_py_reg    <= drd_pkg::PROD_W'(s2_y5_reg) * drd_pkg::PROD_W'(rs_s);
            s3_pw_reg    <= drd_pkg::SPROD_W'(s2_w_reg) * drd_pkg::SPROD_W'(recip_scale_reg);
            s3_ph_reg    <= drd_pkg::SPROD_W'(s2_h_reg) * drd_pkg::SPROD_W'(recip_scale_reg);
            s3_class_reg <= s2_class_reg;
            s3_conf_reg  <= s2_conf_reg;
        end
    end

    drd_axis_map u_map_x (
        .corner_prod (s3_px_reg),
        .size_prod   (s3_pw_reg),
        .image_size  (image_width_reg),
        .corner      (left_c),
        .size        (bw_c)
    );

    drd_axis_map u_map_y (
        .corner_prod (s3_py_reg),
        .size_prod   (s3_ph_reg),
        .image_size  (image_height_reg),
        .corner      (top_c),
        .size        (bh_c)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !boxes.ready;
        if (s3_valid_reg && s3_go)
        begin
            out_valid_next = (bw_c != '0) && (bh_c != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s3_go)
        begin
            out_left_reg  <= left_c;
            out_top_reg   <= top_c;
            out_bw_reg    <= bw_c;
            out_bh_reg    <= bh_c;
            out_class_reg <= s3_class_reg;
            out_conf_reg  <= s3_conf_reg;
        end
    end

    assign boxes.valid       = out_valid_reg;
    assign boxes.left        = out_left_reg;
    assign boxes.top         = out_top_reg;
    assign boxes.box_width   = out_bw_reg;
    assign boxes.box_height  = out_bh_reg;
    assign boxes.class_index = out_class_reg;
    assign boxes.confidence  = out_conf_reg;

endmodule
